>>> hw/rtl/ic3_pkg.sv
// Shared types and constants for the 3x3 streaming convolution block.
// Used by the top level, ic3_ctrl, ic3_kernel and the testbench; depends on nothing.
`default_nettype none

package ic3_pkg;

  localparam int PIXEL_W      = 8;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 2;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;
  localparam int DIM_MIN      = 3;

  localparam logic [PIXEL_W-1:0] PIXEL_MAX = 8'd255;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef logic [PIXEL_W-1:0] pixel_t;

  // window[row][col], row 0 oldest line, col 0 oldest column
  typedef logic [2:0][2:0][PIXEL_W-1:0] window_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_FILTER_MODE  = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_SOBEL_TOP = 2'd0,
    MODE_BLUR      = 2'd1,
    MODE_SHARPEN   = 2'd2,
    MODE_IDENTITY  = 2'd3
  } filter_mode_t;

  typedef struct packed {
    logic shift;
    logic emit;
    logic interior;
    logic last;
    logic bank;
  } item_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/image_convolution_3x3_stream.sv
// 3x3 streaming image convolution: top level with line store, window and output stage.
// Depends on ic3_pkg, ic3_ram, ic3_ctrl and ic3_kernel.
//
// Usage:
//   Requests arrive on req_valid/req_stall with operation and pixel_in; a pixel
//   request carries the next raster pixel, a flush request drains the frame.
//   Results leave on res_valid/res_stall with pixel_out and frame_end.
//   Configuration is written on cfg_wr_en/cfg_index/cfg_data while idle.
//   Throughput is one request per cycle while req_stall is low; the line store is two
//   banks of MAX_WIDTH entries, both read at the column and one written per pixel.
//   A taken request passes stages s1 and s2 before its result is registered at the output.
//   Results lag the input by one row plus one pixel; the last width+1 results
//   of a frame come from requests taken after its last pixel and are zero.
//   Reset clears the counters and window, and selects 640x480, identity mode.
//   The line store is not cleared; stale entries only feed border pixels.
//   When the receiver stalls, the result and up to two requests in flight
//   are held; req_stall rises only when all three stages are occupied.
`default_nettype none

module image_convolution_3x3_stream #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_wr_en,
  input  wire logic [ic3_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [ic3_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                             req_valid,
  output logic                                  req_stall,
  input  wire logic                             operation,
  input  wire logic [ic3_pkg::PIXEL_W-1:0]      pixel_in,
  output logic                                  res_valid,
  input  wire logic                             res_stall,
  output logic      [ic3_pkg::PIXEL_W-1:0]      pixel_out,
  output logic                                  frame_end
);

  import ic3_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  item_ctrl_t   item;
  filter_mode_t mode;
  logic [AW-1:0] ram_addr;
  logic [1:0]    bank_wr;
  pixel_t        rd_data [2];

  logic       take;
  logic       out_free;
  logic       s1_free;
  logic       s2_free;
  logic       s1_move;
  logic       s1_valid;
  logic       s2_valid;
  item_ctrl_t s1_item;
  item_ctrl_t s2_item;
  pixel_t     s1_pix;
  pixel_t     rd_cur;
  pixel_t     rd_prev;
  window_t    win;
  pixel_t     kernel_value;

  ic3_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .operation (operation),
    .item      (item),
    .mode      (mode),
    .ram_addr  (ram_addr),
    .bank_wr   (bank_wr)
  );

  for (genvar b = 0; b < 2; b++) begin : g_bank
    ic3_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk     (clk),
      .wr_en   (bank_wr[b]),
      .wr_addr (ram_addr),
      .wr_data (pixel_in),
      .rd_en   (take),
      .rd_addr (ram_addr),
      .rd_data (rd_data[b])
    );
  end

  ic3_kernel u_kernel (
    .win   (win),
    .mode  (mode),
    .value (kernel_value)
  );

  always_comb begin
    out_free  = !res_valid || !res_stall;
    s2_free   = !s2_valid || out_free;
    s1_free   = !s1_valid || s2_free;
    s1_move   = s1_valid && s2_free;
    take      = req_valid && s1_free;
    req_stall = !s1_free;
    rd_cur    = s1_item.bank ? rd_data[1] : rd_data[0];
    rd_prev   = s1_item.bank ? rd_data[0] : rd_data[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= take;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        res_valid <= s2_valid && s2_item.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_item <= item;
      s1_pix  <= pixel_in;
    end
    if (s2_free) begin
      s2_item <= s1_item;
    end
    if (out_free) begin
      pixel_out <= s2_item.interior ? kernel_value : '0;
      frame_end <= s2_item.last;
    end
  end

  // advance the window by one column per pixel request
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_move && s1_item.shift) begin
      for (int k = 0; k < 3; k++) begin
        win[k][0] <= win[k][1];
        win[k][1] <= win[k][2];
      end
      win[0][2] <= rd_cur;
      win[1][2] <= rd_prev;
      win[2][2] <= s1_pix;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ic3_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`default_nettype none

module ic3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ic3_kernel.sv
// Applies the selected 3x3 kernel to the window, then magnitude and saturation.
// Depends on ic3_pkg.
`default_nettype none

module ic3_kernel (
  input  wire ic3_pkg::window_t      win,
  input  wire ic3_pkg::filter_mode_t mode,
  output ic3_pkg::pixel_t            value
);

  import ic3_pkg::*;

  logic signed [12:0] q [3][3];
  logic signed [12:0] top_sum;
  logic signed [12:0] mid_sum;
  logic signed [12:0] bot_sum;
  logic signed [12:0] blur_sum;
  logic signed [12:0] s;
  logic        [12:0] mag;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        q[r][c] = {5'b0, win[r][c]};
      end
    end
    top_sum  = q[0][0] + (q[0][1] <<< 1) + q[0][2];
    mid_sum  = (q[1][0] <<< 1) + (q[1][1] <<< 2) + (q[1][2] <<< 1);
    bot_sum  = q[2][0] + (q[2][1] <<< 1) + q[2][2];
    blur_sum = top_sum + mid_sum + bot_sum;
    case (mode)
      MODE_SOBEL_TOP: s = top_sum - bot_sum;
      MODE_BLUR:      s = blur_sum >>> 4;
      MODE_SHARPEN:   s = (q[1][1] <<< 2) + q[1][1] - q[0][1] - q[1][0] - q[1][2] - q[2][1];
      default:        s = q[1][1];
    endcase
    mag   = s[12] ? 13'(-s) : 13'(s);
    value = (mag > 13'(PIXEL_MAX)) ? PIXEL_MAX : mag[7:0];
  end

endmodule

`default_nettype wire

>>> hw/rtl/ic3_ctrl.sv
// Configuration registers, raster counters and line store addressing.
// Decodes each request into an item control word. Depends on ic3_pkg.
`default_nettype none

module ic3_ctrl #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [ic3_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [ic3_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire logic                                 take,
  input  wire logic                                 operation,
  output ic3_pkg::item_ctrl_t                       item,
  output ic3_pkg::filter_mode_t                     mode,
  output logic      [$clog2(MAX_WIDTH)-1:0]         ram_addr,
  output logic      [1:0]                           bank_wr
);

  import ic3_pkg::*;

  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int HW      = $clog2(MAX_HEIGHT + 1);
  localparam int CW      = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int RESET_W = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int RESET_H = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;
  localparam int RESET_T = RESET_W * RESET_H;

  logic [WW-1:0] width_eff;
  logic [HW-1:0] height_eff;
  logic [CW-1:0] total;
  logic [WW-1:0] width_next;
  logic [HW-1:0] height_next;
  logic [CW-1:0] total_next;
  logic [31:0]   w_sel;
  logic [31:0]   h_sel;
  logic [31:0]   w_clamp;
  logic [31:0]   h_clamp;

  logic [AW-1:0] in_column;
  logic [HW-1:0] in_row;
  logic [CW-1:0] out_count;
  logic [AW-1:0] in_column_next;
  logic [HW-1:0] in_row_next;
  logic [CW-1:0] out_count_next;

  logic          complete;
  logic          pixel;
  logic          ready;
  logic          last;
  logic [WW-1:0] col_ext;
  logic [WW-1:0] col_inc;
  logic [CW:0]   count_inc;

  always_comb begin
    w_sel = (cfg_index == CFG_IMAGE_WIDTH) ? 32'(cfg_data) : 32'(width_eff);
    h_sel = (cfg_index == CFG_IMAGE_HEIGHT) ? 32'(cfg_data) : 32'(height_eff);
    if (w_sel < 32'(DIM_MIN)) begin
      w_clamp = 32'(DIM_MIN);
    end else if (w_sel > 32'(MAX_WIDTH)) begin
      w_clamp = 32'(MAX_WIDTH);
    end else begin
      w_clamp = w_sel;
    end
    if (h_sel < 32'(DIM_MIN)) begin
      h_clamp = 32'(DIM_MIN);
    end else if (h_sel > 32'(MAX_HEIGHT)) begin
      h_clamp = 32'(MAX_HEIGHT);
    end else begin
      h_clamp = h_sel;
    end
    width_next  = WW'(w_clamp);
    height_next = HW'(h_clamp);
    total_next  = CW'(width_next) * CW'(height_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WW'(RESET_W);
      height_eff <= HW'(RESET_H);
      total      <= CW'(RESET_T);
      mode       <= MODE_IDENTITY;
    end else if (cfg_wr_en) begin
      width_eff  <= width_next;
      height_eff <= height_next;
      total      <= total_next;
      if (cfg_index == CFG_FILTER_MODE) begin
        mode <= filter_mode_t'(cfg_data[1:0]);
      end
    end
  end

  always_comb begin
    complete  = in_row >= height_eff;
    pixel     = (operation == OP_PIXEL) && !complete;
    col_ext   = WW'(in_column);
    col_inc   = col_ext + WW'(1);
    ready     = (in_row >= HW'(2)) || ((in_row == HW'(1)) && (in_column != '0));
    count_inc = (CW + 1)'(out_count) + (CW + 1)'(1);
    last      = count_inc >= (CW + 1)'(total);

    item.shift    = pixel;
    item.emit     = complete || (pixel && ready);
    item.interior = (in_row >= HW'(2)) && (in_column >= AW'(2)) && (col_ext < width_eff);
    item.last     = last;
    item.bank     = in_row[0];

    ram_addr   = in_column;
    bank_wr[0] = take && pixel && !in_row[0];
    bank_wr[1] = take && pixel && in_row[0];

    in_column_next = in_column;
    in_row_next    = in_row;
    out_count_next = out_count;
    if (pixel) begin
      if (col_inc >= width_eff) begin
        in_column_next = '0;
        in_row_next    = in_row + HW'(1);
      end else begin
        in_column_next = AW'(col_inc);
      end
    end
    if (item.emit) begin
      if (last) begin
        in_column_next = '0;
        in_row_next    = '0;
        out_count_next = '0;
      end else begin
        out_count_next = CW'(count_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
      out_count <= '0;
    end else if (take) begin
      in_column <= in_column_next;
      in_row    <= in_row_next;
      out_count <= out_count_next;
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_image_convolution_3x3_stream.sv
// Self-checking bench for image_convolution_3x3_stream: directed and random frames under
// several idle and stall mixes, each result checked against a local convolution predictor.
// Depends on ic3_pkg and the image_convolution_3x3_stream RTL.

import ic3_pkg::*;

class conv_scoreboard;
  localparam int MAX_DIM = 4096;

  typedef struct {
    pixel_t value;
    logic   last;
  } out_pixel_t;

  pixel_t       line_mem [2*MAX_DIM];
  pixel_t       win [3][3];
  int unsigned  col;
  int unsigned  row;
  int unsigned  out_seen;
  logic [12:0]  width_reg;
  logic [12:0]  height_reg;
  filter_mode_t mode;
  out_pixel_t   awaited[$];
  int           errors;

  function new();
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[r, c]) win[r][c] = '0;
    col        = 0;
    row        = 0;
    out_seen   = 0;
    width_reg  = 13'(WIDTH_RESET);
    height_reg = 13'(HEIGHT_RESET);
    mode       = MODE_IDENTITY;
    errors     = 0;
  endfunction

  function int unsigned clamp_dim(logic [12:0] v);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  function bit frame_idle();
    return row == 0 && col == 0 && out_seen == 0;
  endfunction

  function void note_config(cfg_index_t idx, logic [12:0] data);
    case (idx)
      CFG_IMAGE_WIDTH:  width_reg = data;
      CFG_IMAGE_HEIGHT: height_reg = data;
      CFG_FILTER_MODE:  mode = filter_mode_t'(data[1:0]);
      default: ;
    endcase
  endfunction

  function pixel_t filter_window();
    int p [3][3];
    int s;
    foreach (win[r, c]) p[r][c] = int'(win[r][c]);
    case (mode)
      MODE_SOBEL_TOP: s = p[0][0] + 2*p[0][1] + p[0][2] - p[2][0] - 2*p[2][1] - p[2][2];
      MODE_BLUR:      s = (p[0][0] + 2*p[0][1] + p[0][2] + 2*p[1][0] + 4*p[1][1]
                          + 2*p[1][2] + p[2][0] + 2*p[2][1] + p[2][2]) / 16;
      MODE_SHARPEN:   s = 5*p[1][1] - p[0][1] - p[1][0] - p[1][2] - p[2][1];
      default:        s = p[1][1];
    endcase
    if (s < 0) s = -s;
    if (s > 255) s = 255;
    return pixel_t'(s);
  endfunction

  function void push_result(pixel_t value, int unsigned total);
    out_pixel_t item;
    item.value = value;
    item.last  = (out_seen + 1 >= total);
    awaited.push_back(item);
    out_seen++;
    if (item.last) begin
      row      = 0;
      col      = 0;
      out_seen = 0;
    end
  endfunction

  // returns 1 unless the request is an ignored flush
  function bit note_request(logic op, pixel_t pix);
    int unsigned w, h, total, r, c, cur, prev;
    bit ready;
    pixel_t value;
    w     = clamp_dim(width_reg);
    h     = clamp_dim(height_reg);
    total = w * h;
    if (op == OP_FLUSH || row >= h) begin
      if (row < h) return 0;
      push_result('0, total);
      return 1;
    end
    r = row;
    c = (col >= MAX_DIM) ? MAX_DIM - 1 : col;
    cur  = (r & 1) * MAX_DIM + c;
    prev = ((r + 1) & 1) * MAX_DIM + c;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = line_mem[cur];
    win[1][2] = line_mem[prev];
    win[2][2] = pix;
    line_mem[cur] = pix;
    ready = (r >= 2) || (r == 1 && c >= 1);
    value = '0;
    if (ready && c >= 1 && r != 1 && r < h && c != 1 && c < w) value = filter_window();
    col++;
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (ready) push_result(value, total);
    return 1;
  endfunction

  function void check_result(pixel_t got, logic got_end);
    out_pixel_t want;
    if (awaited.size() == 0) begin
      errors++;
      $display("%0t: unexpected result pixel_out %0d frame_end %0b", $time, got, got_end);
      return;
    end
    want = awaited.pop_front();
    if (got !== want.value) begin
      errors++;
      $display("%0t: pixel_out expected %0d actual %0d", $time, want.value, got);
    end
    if (got_end !== want.last) begin
      errors++;
      $display("%0t: frame_end expected %0b actual %0b", $time, want.last, got_end);
    end
  endfunction
endclass

module tb_image_convolution_3x3_stream;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   req_valid = 1'b0;
  logic                   req_stall;
  logic                   operation = OP_PIXEL;
  pixel_t                 pixel_in = '0;
  logic                   res_valid;
  logic                   res_stall = 1'b0;
  pixel_t                 pixel_out;
  logic                   frame_end;

  conv_scoreboard book = new();

  int send_idle = 0;
  int stall_pct = 0;
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet     = 0;
  int items_done = 0;

  image_convolution_3x3_stream dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall),
    .operation(operation), .pixel_in(pixel_in),
    .res_valid(res_valid), .res_stall(res_stall),
    .pixel_out(pixel_out), .frame_end(frame_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: check, then choose the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) book.check_result(pixel_out, frame_end);
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("image_convolution_3x3_stream verification failed");
        $finish;
      end
    end
  end

  function automatic pixel_t rand_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return PIXEL_MAX;
      default: return pixel_t'($urandom_range(255));
    endcase
  endfunction

  task automatic push_request(logic op, pixel_t pix);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    pixel_in  <= pix;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (book.note_request(op, pix)) items_done++;
  endtask

  // drop valid, wait for every result, then let the pipeline settle
  task automatic drain_requests();
    req_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    book.note_config(idx, data);
  endtask

  task automatic configure(logic [12:0] w_reg, logic [12:0] h_reg, filter_mode_t mode);
    drain_requests();
    write_reg(CFG_IMAGE_WIDTH, w_reg);
    write_reg(CFG_IMAGE_HEIGHT, h_reg);
    write_reg(CFG_FILTER_MODE, CFG_DATA_W'(mode));
    cfg_wr_en <= 1'b0;
  endtask

  task automatic finish_frame(bit noisy);
    while (!book.frame_idle())
      push_request(($urandom_range(9) < 3) ? OP_PIXEL : OP_FLUSH, rand_pixel());
    if (noisy && $urandom_range(3) == 0) push_request(OP_FLUSH, rand_pixel());
  endtask

  task automatic send_frame(logic [12:0] w_reg, logic [12:0] h_reg, filter_mode_t mode,
                            bit noisy);
    int unsigned n;
    configure(w_reg, h_reg, mode);
    n = book.clamp_dim(w_reg) * book.clamp_dim(h_reg);
    for (int unsigned i = 0; i < n; i++) begin
      if (noisy && $urandom_range(19) == 0) push_request(OP_FLUSH, rand_pixel());
      push_request(OP_PIXEL, rand_pixel());
    end
    finish_frame(noisy);
  endtask

  // start a frame at the given size, then cut it to 3x3 part way through
  task automatic cut_frame(logic [12:0] w_reg, logic [12:0] h_reg, filter_mode_t mode,
                           int unsigned n);
    configure(w_reg, h_reg, mode);
    for (int unsigned i = 0; i < n; i++) push_request(OP_PIXEL, rand_pixel());
    configure(13'd3, 13'd3, mode);
    finish_frame(1'b0);
  endtask

  task automatic random_frame();
    logic [12:0] w_reg, h_reg;
    w_reg = ($urandom_range(9) == 0) ? 13'($urandom_range(2)) : 13'($urandom_range(3, 12));
    h_reg = ($urandom_range(9) == 0) ? 13'($urandom_range(2)) : 13'($urandom_range(3, 8));
    send_frame(w_reg, h_reg, filter_mode_t'($urandom_range(3)), 1'b1);
  endtask

  initial begin
    int quota;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // smallest frame in the reset mode, with a flush inside and a pixel after the end
    drain_requests();
    write_reg(CFG_IMAGE_WIDTH, 13'd3);
    write_reg(CFG_IMAGE_HEIGHT, 13'd3);
    cfg_wr_en <= 1'b0;
    for (int i = 0; i < 9; i++) begin
      if (i == 4) push_request(OP_FLUSH, PIXEL_MAX);
      push_request(OP_PIXEL, (i % 2 == 0) ? PIXEL_MAX : pixel_t'(0));
    end
    push_request(OP_PIXEL, PIXEL_MAX);
    finish_frame(1'b0);

    // shrink the height in the middle of a frame
    configure(13'd3, 13'd5, MODE_SHARPEN);
    for (int i = 0; i < 9; i++) push_request(OP_PIXEL, rand_pixel());
    drain_requests();
    write_reg(CFG_IMAGE_HEIGHT, 13'd3);
    cfg_wr_en <= 1'b0;
    finish_frame(1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 73; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 73; end
        default: begin send_idle = 25; stall_pct = 25; end
      endcase
      if (phase == 0) begin
        send_frame(13'd0, 13'd0, MODE_IDENTITY, 1'b0);
        cut_frame(13'd4096, 13'd3, MODE_BLUR, 40);
        cut_frame(13'd3, 13'h1FFF, MODE_SOBEL_TOP, 30);
        cut_frame(13'h1FFF, 13'd3, MODE_SHARPEN, 40);
        // hold the receiver off while the sender keeps offering
        configure(13'd16, 13'd6, MODE_SHARPEN);
        hold_req++;
        for (int i = 0; i < 96; i++) push_request(OP_PIXEL, rand_pixel());
        finish_frame(1'b0);
      end
      quota = items_done + 190;
      while (items_done < quota) random_frame();
    end

    drain_requests();
    repeat (16) @(posedge clk);
    if (book.errors == 0 && book.pending() == 0) begin
      $display("image_convolution_3x3_stream verification clean");
    end else begin
      $display("image_convolution_3x3_stream verification failed");
    end
    $finish;
  end
endmodule

>>> files.f
hw/rtl/ic3_pkg.sv
hw/rtl/ic3_ram.sv
hw/rtl/ic3_kernel.sv
hw/rtl/ic3_ctrl.sv
hw/rtl/image_convolution_3x3_stream.sv
dv/tb_image_convolution_3x3_stream.sv
